// ===== rtl/baur_pkg.sv =====
// ----------------------------------------------------------------------------
// baur_pkg
// shared types and codes for the batched-ack upload receiver
// ----------------------------------------------------------------------------
`default_nettype none
package baur_pkg;

   localparam logic [2:0] CMD_START  = 3'd0;
   localparam logic [2:0] CMD_BLOCK  = 3'd1;
   localparam logic [2:0] CMD_END    = 3'd2;
   localparam logic [2:0] CMD_CANCEL = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_START  = 3'd1;
   localparam logic [2:0] KIND_BLOCK  = 3'd2;
   localparam logic [2:0] KIND_END    = 3'd3;
   localparam logic [2:0] KIND_CANCEL = 3'd4;
   localparam logic [2:0] KIND_ERROR  = 3'd5;

   localparam logic [2:0] RSN_NONE       = 3'd0;
   localparam logic [2:0] RSN_UNEXPECTED = 3'd1;
   localparam logic [2:0] RSN_FIRST_FW   = 3'd2;
   localparam logic [2:0] RSN_FW         = 3'd3;
   localparam logic [2:0] RSN_FILE       = 3'd4;
   localparam logic [2:0] RSN_RETRIES    = 3'd5;
   localparam logic [2:0] RSN_TIMEOUT    = 3'd6;
   localparam logic [2:0] RSN_HOST       = 3'd7;

   localparam logic [2:0] REG_FIRST_TO   = 3'd0;
   localparam logic [2:0] REG_BLOCK_TO   = 3'd1;
   localparam logic [2:0] REG_OVERALL_TO = 3'd2;
   localparam logic [2:0] REG_RETRIES    = 3'd3;
   localparam logic [2:0] REG_DEF_BLOCK  = 3'd4;
   localparam logic [2:0] REG_DEF_BATCH  = 3'd5;
   localparam logic [2:0] REG_BATCH_MAX  = 3'd6;
   localparam logic [2:0] REG_FIRMWARE   = 3'd7;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture the request
      logic prep;      // compute sizes / compare stage
      logic div_start; // begin batch division
      logic div_step;  // one quotient bit
      logic commit;    // update state and build response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/baur_ctrl.sv =====
// ----------------------------------------------------------------------------
// baur_ctrl
// sequencer: load, prepare, optional division, commit, present result
// ----------------------------------------------------------------------------
`default_nettype none
module baur_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output baur_pkg::cmd_type     cmd,
   input  wire baur_pkg::sts_type sts
);
   import baur_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP   = 6'b000010,
      ST_DSTART = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_COMMIT = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ===== rtl/baur_dpath.sv =====
// ----------------------------------------------------------------------------
// baur_dpath
// upload state, size negotiation, restoring divider and response build
// ----------------------------------------------------------------------------
`default_nettype none
module baur_dpath #(
   parameter int unsigned MIN_BLOCK_SIZE = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire baur_pkg::cmd_type cmd,
   output baur_pkg::sts_type      sts,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   input  wire logic [2:0]        req_cmd,
   input  wire logic [31:0]       req_file_length,
   input  wire logic [15:0]       req_host_block_size,
   input  wire logic [15:0]       req_host_batch_size,
   input  wire logic [15:0]       req_channel_block_max,
   input  wire logic [31:0]       req_block_position,
   input  wire logic [15:0]       req_block_length,
   input  wire logic              req_sink_error,
   output logic [2:0]             rsp_resp_kind,
   output logic                   rsp_success,
   output logic                   rsp_send_okto,
   output logic [31:0]            rsp_okto_position,
   output logic                   rsp_block_write,
   output logic                   rsp_first_block,
   output logic                   rsp_final_block,
   output logic                   rsp_cancel_sent,
   output logic [2:0]             rsp_cancel_reason,
   output logic [15:0]            rsp_granted_block_size,
   output logic [15:0]            rsp_granted_batch_size
);
   import baur_pkg::*;

   localparam logic [15:0] MinBs = 16'(MIN_BLOCK_SIZE);
   localparam int DivBits = 23;

   // configuration
   logic [31:0] first_to_ff, block_to_ff, overall_to_ff;
   logic [7:0]  max_retries_ff;
   logic [15:0] def_block_ff, def_batch_ff;
   logic [22:0] batch_max_ff;
   logic        firmware_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_to_ff    <= 32'd10000;
         block_to_ff    <= 32'd2000;
         overall_to_ff  <= 32'd7200000;
         max_retries_ff <= 8'd5;
         def_block_ff   <= 16'd500;
         def_batch_ff   <= 16'd40;
         batch_max_ff   <= 23'd50000;
         firmware_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FIRST_TO:   first_to_ff    <= csr_data;
            REG_BLOCK_TO:   block_to_ff    <= csr_data;
            REG_OVERALL_TO: overall_to_ff  <= csr_data;
            REG_RETRIES:    max_retries_ff <= csr_data[7:0];
            REG_DEF_BLOCK:  def_block_ff   <= csr_data[15:0];
            REG_DEF_BATCH:  def_batch_ff   <= csr_data[15:0];
            REG_BATCH_MAX:  batch_max_ff   <= csr_data[22:0];
            REG_FIRMWARE:   firmware_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // captured request
   logic [2:0]  c_cmd_ff;
   logic [31:0] c_len_ff, c_pos_ff;
   logic [15:0] c_hbs_ff, c_hbt_ff, c_chan_ff, c_blen_ff;
   logic        c_serr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_cmd_ff  <= req_cmd;
         c_len_ff  <= req_file_length;
         c_hbs_ff  <= req_host_block_size;
         c_hbt_ff  <= req_host_batch_size;
         c_chan_ff <= req_channel_block_max;
         c_pos_ff  <= req_block_position;
         c_blen_ff <= req_block_length;
         c_serr_ff <= req_sink_error;
      end
   end

   // upload state
   logic        uploading_ff;
   logic [31:0] exp_pos_ff, up_len_ff, vcount_ff, time_ff, last_ff, start_ff;
   logic [15:0] bcount_ff, bsize_ff, btsize_ff;
   logic [7:0]  retries_ff;

   // prep stage: negotiated sizes, product and timing diffs
   logic [15:0] bs_ff, bt_ff;
   logic [38:0] prod_ff;
   logic        start_ok_ff;
   logic [31:0] tnext_ff, idle_ff, run_ff;

   logic [15:0] bs_req, bt_req, bs_cl;
   logic [17:0] hi_x2;
   logic [16:0] hi;
   logic [31:0] tnext;

   always_comb begin
      bs_req = (c_hbs_ff != '0) ? c_hbs_ff : def_block_ff;
      bt_req = (c_hbt_ff != '0) ? c_hbt_ff : def_batch_ff;
      hi_x2  = {1'b0, c_chan_ff, 1'b0};
      // x*2/3 via reciprocal: (v*43691)>>17 exact for v < 2^17
      hi     = 17'(({16'd0, hi_x2} * 34'd43691) >> 17);
      if (bs_req < MinBs) bs_cl = MinBs;
      else if (c_chan_ff != '0 && {1'b0, bs_req} > hi) bs_cl = hi[15:0];
      else bs_cl = bs_req;
      tnext = time_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         bs_ff       <= bs_cl;
         bt_ff       <= bt_req;
         start_ok_ff <= !(uploading_ff && exp_pos_ff != '0);
         tnext_ff    <= tnext;
         idle_ff     <= tnext - last_ff;
         run_ff      <= tnext - start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) prod_ff <= 39'(bs_cl) * 39'(bt_req);
   end

   assign sts.need_div = (c_cmd_ff == CMD_START) && start_ok_ff && (bs_ff != '0)
                         && (prod_ff > 39'(batch_max_ff));

   // restoring divider: batch_max / bs, one bit a cycle
   logic [22:0] quo_ff, rem_ff;
   logic [4:0]  dcnt_ff;
   logic [23:0] trial;
   always_comb trial = {rem_ff, quo_ff[22]} - {8'd0, bs_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= batch_max_ff;
         rem_ff  <= '0;
         dcnt_ff <= 5'(DivBits - 1);
      end else if (cmd.div_step) begin
         if (!trial[23]) begin
            rem_ff <= trial[22:0];
            quo_ff <= {quo_ff[21:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[21:0], quo_ff[22]};
            quo_ff <= {quo_ff[21:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end
   assign sts.div_done = (dcnt_ff == '0);

   // commit
   logic        up_in;
   logic [31:0] exp_in, len_in, vc_in, last_in, start_in;
   logic [15:0] bc_in, bsz_in, btz_in, bt_fin;
   logic [7:0]  rt_in;
   logic        valid_blk, fin, ack;
   logic [32:0] endp;
   logic [31:0] limit;

   logic [2:0]  o_kind, o_reason;
   logic        o_succ, o_okto, o_wr, o_first, o_final, o_cancel;
   logic [31:0] o_pos;
   logic [15:0] o_gbs, o_gbt;

   always_comb begin
      up_in = uploading_ff; exp_in = exp_pos_ff; len_in = up_len_ff;
      vc_in = vcount_ff; last_in = last_ff; start_in = start_ff;
      bc_in = bcount_ff; bsz_in = bsize_ff; btz_in = btsize_ff; rt_in = retries_ff;
      o_kind = KIND_NONE; o_reason = RSN_NONE; o_succ = 1'b0; o_okto = 1'b0;
      o_wr = 1'b0; o_first = 1'b0; o_final = 1'b0; o_cancel = 1'b0;
      o_pos = '0; o_gbs = '0; o_gbt = '0;
      valid_blk = 1'b0; fin = 1'b0; ack = 1'b0;
      endp = {1'b0, c_pos_ff} + {17'd0, c_blen_ff};
      limit = (vcount_ff < 32'd2) ? first_to_ff : block_to_ff;
      bt_fin = bt_ff;
      if (sts.need_div) bt_fin = (quo_ff == '0) ? 16'd1 : quo_ff[15:0];
      case (c_cmd_ff)
         CMD_START: begin
            o_kind = KIND_START;
            if (start_ok_ff) begin
               len_in = c_len_ff; up_in = 1'b1; start_in = time_ff; last_in = time_ff;
               vc_in = '0; exp_in = '0; bc_in = '0; rt_in = '0;
               bsz_in = bs_ff; btz_in = bt_fin; o_succ = 1'b1;
            end
            o_gbs = bsz_in; o_gbt = btz_in;
         end
         CMD_BLOCK: begin
            if (!uploading_ff) begin
               o_kind = KIND_ERROR; up_in = 1'b0;
               o_cancel = 1'b1; o_reason = RSN_UNEXPECTED;
            end else begin
               bc_in = bcount_ff + 16'd1;
               last_in = time_ff;
               if (c_pos_ff == exp_pos_ff) begin
                  valid_blk = 1'b1;
                  exp_in = exp_pos_ff + {16'd0, c_blen_ff};
                  vc_in = vcount_ff + 32'd1;
                  o_first = (c_pos_ff == '0);
                  fin = (endp >= {1'b0, up_len_ff});
               end
               ack = (bc_in == btsize_ff) || (vc_in == 32'd1) || fin;
               if (ack) bc_in = '0;
               rt_in = '0;
               o_wr = valid_blk; o_final = fin;
               if (ack) begin
                  o_kind = KIND_BLOCK; o_succ = 1'b1; o_okto = 1'b1; o_pos = exp_in;
               end
               if (valid_blk && c_serr_ff) begin
                  o_kind = KIND_BLOCK; o_succ = 1'b0; o_okto = 1'b0; o_pos = '0;
                  up_in = 1'b0; o_cancel = 1'b1;
                  if (firmware_ff) o_reason = o_first ? RSN_FIRST_FW : RSN_FW;
                  else o_reason = RSN_FILE;
               end
            end
         end
         CMD_END: begin
            up_in = 1'b0; o_kind = KIND_END; o_succ = 1'b1;
         end
         CMD_CANCEL: begin
            up_in = 1'b0; o_cancel = 1'b1; o_reason = RSN_HOST;
            o_kind = KIND_CANCEL; o_succ = 1'b1;
         end
         CMD_TICK: begin
            if (uploading_ff) begin
               if (idle_ff > limit) begin
                  rt_in = retries_ff + 8'd1;
                  if (rt_in < max_retries_ff) begin
                     last_in = tnext_ff;
                     o_kind = KIND_BLOCK; o_succ = 1'b1; o_okto = 1'b1; o_pos = exp_pos_ff;
                  end else begin
                     up_in = 1'b0; o_cancel = 1'b1; o_reason = RSN_RETRIES;
                  end
               end else if (run_ff > overall_to_ff) begin
                  up_in = 1'b0; o_cancel = 1'b1; o_reason = RSN_TIMEOUT;
               end
            end
         end
         default: o_kind = KIND_ERROR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uploading_ff <= 1'b0; exp_pos_ff <= '0; up_len_ff <= '0; vcount_ff <= '0;
         bcount_ff <= '0; retries_ff <= '0; time_ff <= '0; last_ff <= '0;
         start_ff <= '0; bsize_ff <= '0; btsize_ff <= '0;
      end else if (cmd.commit) begin
         uploading_ff <= up_in; exp_pos_ff <= exp_in; up_len_ff <= len_in;
         vcount_ff <= vc_in; bcount_ff <= bc_in; retries_ff <= rt_in;
         last_ff <= last_in; start_ff <= start_in; bsize_ff <= bsz_in;
         btsize_ff <= btz_in;
         if (c_cmd_ff == CMD_TICK) time_ff <= tnext_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_resp_kind <= o_kind; rsp_success <= o_succ; rsp_send_okto <= o_okto;
         rsp_okto_position <= o_pos; rsp_block_write <= o_wr;
         rsp_first_block <= o_first; rsp_final_block <= o_final;
         rsp_cancel_sent <= o_cancel; rsp_cancel_reason <= o_reason;
         rsp_granted_block_size <= o_gbs; rsp_granted_batch_size <= o_gbt;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/batched_ack_upload_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// batched_ack_upload_receiver_unit
// receiver for block uploads with batched ok-to acknowledgements
// ----------------------------------------------------------------------------
// One transaction in, one result out. A request passes load, prepare, decide,
// commit and present; a start whose batch must be cut to the byte limit adds a
// bit-serial division of max_batch_bytes by the block size between decide and
// commit. The next request is taken once the result is consumed.
`default_nettype none
module batched_ack_upload_receiver_unit #(
   parameter int unsigned MIN_BLOCK_SIZE = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [31:0] req_file_length,
   input  wire logic [15:0] req_host_block_size,
   input  wire logic [15:0] req_host_batch_size,
   input  wire logic [15:0] req_channel_block_max,
   input  wire logic [31:0] req_block_position,
   input  wire logic [15:0] req_block_length,
   input  wire logic        req_sink_error,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_resp_kind,
   output logic             rsp_success,
   output logic             rsp_send_okto,
   output logic [31:0]      rsp_okto_position,
   output logic             rsp_block_write,
   output logic             rsp_first_block,
   output logic             rsp_final_block,
   output logic             rsp_cancel_sent,
   output logic [2:0]       rsp_cancel_reason,
   output logic [15:0]      rsp_granted_block_size,
   output logic [15:0]      rsp_granted_batch_size
);
   import baur_pkg::*;

   cmd_type cmd;
   sts_type sts;

   baur_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   baur_dpath #(.MIN_BLOCK_SIZE(MIN_BLOCK_SIZE)) u_dpath (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_cmd, .req_file_length, .req_host_block_size, .req_host_batch_size,
      .req_channel_block_max, .req_block_position, .req_block_length,
      .req_sink_error, .rsp_resp_kind, .rsp_success, .rsp_send_okto,
      .rsp_okto_position, .rsp_block_write, .rsp_first_block, .rsp_final_block,
      .rsp_cancel_sent, .rsp_cancel_reason, .rsp_granted_block_size,
      .rsp_granted_batch_size
   );
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the batched-ack upload receiver: directed and
// random transactions against an in-bench prediction of every response
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import baur_pkg::*;

   localparam int unsigned MIN_BLK = 16;
   localparam int unsigned LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] file_length;
      logic [15:0] host_block_size;
      logic [15:0] host_batch_size;
      logic [15:0] channel_block_max;
      logic [31:0] block_position;
      logic [15:0] block_length;
      logic        sink_error;
   } upload_req_t;

   typedef struct packed {
      logic [2:0]  resp_kind;
      logic        success;
      logic        send_okto;
      logic [31:0] okto_position;
      logic        block_write;
      logic        first_block;
      logic        final_block;
      logic        cancel_sent;
      logic [2:0]  cancel_reason;
      logic [15:0] granted_block_size;
      logic [15:0] granted_batch_size;
   } upload_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   upload_req_t req_bus = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   upload_rsp_t rsp_bus;

   batched_ack_upload_receiver_unit #(.MIN_BLOCK_SIZE(MIN_BLK)) DUT (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_bus.cmd), .req_file_length(req_bus.file_length),
      .req_host_block_size(req_bus.host_block_size),
      .req_host_batch_size(req_bus.host_batch_size),
      .req_channel_block_max(req_bus.channel_block_max),
      .req_block_position(req_bus.block_position),
      .req_block_length(req_bus.block_length),
      .req_sink_error(req_bus.sink_error),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_resp_kind(rsp_bus.resp_kind), .rsp_success(rsp_bus.success),
      .rsp_send_okto(rsp_bus.send_okto), .rsp_okto_position(rsp_bus.okto_position),
      .rsp_block_write(rsp_bus.block_write), .rsp_first_block(rsp_bus.first_block),
      .rsp_final_block(rsp_bus.final_block), .rsp_cancel_sent(rsp_bus.cancel_sent),
      .rsp_cancel_reason(rsp_bus.cancel_reason),
      .rsp_granted_block_size(rsp_bus.granted_block_size),
      .rsp_granted_batch_size(rsp_bus.granted_batch_size)
   );

   // predicted receiver state and registers
   logic [31:0] r_first_to, r_block_to, r_overall_to;
   logic [7:0]  r_retries;
   logic [15:0] r_def_block, r_def_batch;
   logic [22:0] r_batch_max;
   logic        r_firmware;
   logic        s_uploading;
   logic [31:0] s_exp_pos, s_length, s_valid_cnt, s_now, s_last_msg, s_start;
   logic [15:0] s_batch_cnt, s_blk_size, s_batch_size;
   logic [7:0]  s_retry_cnt;

   upload_req_t pending_reqs[$];
   upload_rsp_t expected_rsps[$];
   int unsigned errors = 0;
   int unsigned accepted = 0;
   int unsigned received = 0;
   int unsigned acks_seen = 0;
   int unsigned cancels_seen = 0;
   int unsigned cycles = 0;
   logic pause_sender = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   logic req_taken = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic upload_rsp_t predict_upload(upload_req_t rq);
      upload_rsp_t o;
      logic [31:0] bs, bt, hi, lim;
      logic [63:0] tot;
      logic valid, first, fin, ack;
      o = '0;
      case (rq.cmd)
         CMD_START: begin
            o.resp_kind = KIND_START;
            if (s_uploading && s_exp_pos > 0) begin
               o.success = 1'b0;
            end else begin
               s_length = rq.file_length;
               s_uploading = 1'b1;
               s_start = s_now;
               s_last_msg = s_now;
               s_valid_cnt = '0;
               s_exp_pos = '0;
               s_batch_cnt = '0;
               s_retry_cnt = '0;
               bs = (rq.host_block_size != 0) ? 32'(rq.host_block_size) : 32'(r_def_block);
               bt = (rq.host_batch_size != 0) ? 32'(rq.host_batch_size) : 32'(r_def_batch);
               hi = (rq.channel_block_max != 0) ? 32'(rq.channel_block_max) * 2 / 3 : bs;
               if (bs < MIN_BLK) bs = MIN_BLK;
               else if (bs > hi) bs = hi;
               bs = bs & 32'hFFFF;
               tot = 64'(bs) * 64'(bt);
               if (bs != 0 && tot > 64'(r_batch_max)) begin
                  bt = 32'(r_batch_max) / bs;
                  if (bt == 0) bt = 32'd1;
               end
               s_blk_size = bs[15:0];
               s_batch_size = bt[15:0];
               o.success = 1'b1;
            end
            o.granted_block_size = s_blk_size;
            o.granted_batch_size = s_batch_size;
         end
         CMD_BLOCK: begin
            if (!s_uploading) begin
               o.resp_kind = KIND_ERROR;
               s_uploading = 1'b0;
               o.cancel_sent = 1'b1;
               o.cancel_reason = RSN_UNEXPECTED;
            end else begin
               valid = 1'b0; first = 1'b0; fin = 1'b0;
               s_batch_cnt = s_batch_cnt + 16'd1;
               s_last_msg = s_now;
               if (rq.block_position == s_exp_pos) begin
                  valid = 1'b1;
                  s_exp_pos = s_exp_pos + 32'(rq.block_length);
                  s_valid_cnt = s_valid_cnt + 32'd1;
                  first = (rq.block_position == 0);
                  fin = (33'(rq.block_position) + 33'(rq.block_length)) >= 33'(s_length);
               end
               ack = (s_batch_cnt == s_batch_size) || (s_valid_cnt == 1) || fin;
               if (ack) s_batch_cnt = '0;
               s_retry_cnt = '0;
               o.block_write = valid;
               o.first_block = first;
               o.final_block = fin;
               if (ack) begin
                  o.resp_kind = KIND_BLOCK;
                  o.success = 1'b1;
                  o.send_okto = 1'b1;
                  o.okto_position = s_exp_pos;
               end
               if (valid && rq.sink_error) begin
                  o.resp_kind = KIND_BLOCK;
                  o.success = 1'b0;
                  o.send_okto = 1'b0;
                  o.okto_position = '0;
                  s_uploading = 1'b0;
                  o.cancel_sent = 1'b1;
                  o.cancel_reason = !r_firmware ? RSN_FILE : (first ? RSN_FIRST_FW : RSN_FW);
               end
            end
         end
         CMD_END: begin
            s_uploading = 1'b0;
            o.resp_kind = KIND_END;
            o.success = 1'b1;
         end
         CMD_CANCEL: begin
            s_uploading = 1'b0;
            o.cancel_sent = 1'b1;
            o.cancel_reason = RSN_HOST;
            o.resp_kind = KIND_CANCEL;
            o.success = 1'b1;
         end
         CMD_TICK: begin
            s_now = s_now + 32'd1;
            if (s_uploading) begin
               lim = (s_valid_cnt < 2) ? r_first_to : r_block_to;
               if (s_now - s_last_msg > lim) begin
                  s_retry_cnt = s_retry_cnt + 8'd1;
                  if (s_retry_cnt < r_retries) begin
                     s_last_msg = s_now;
                     o.resp_kind = KIND_BLOCK;
                     o.success = 1'b1;
                     o.send_okto = 1'b1;
                     o.okto_position = s_exp_pos;
                  end else begin
                     s_uploading = 1'b0;
                     o.cancel_sent = 1'b1;
                     o.cancel_reason = RSN_RETRIES;
                  end
               end else if (s_now - s_start > r_overall_to) begin
                  s_uploading = 1'b0;
                  o.cancel_sent = 1'b1;
                  o.cancel_reason = RSN_TIMEOUT;
               end
            end
         end
         default: o.resp_kind = KIND_ERROR;
      endcase
      return o;
   endfunction

   // sender: bursts and gaps, payload changes on the falling edge only
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (!pause_sender && pending_reqs.size() > 0) begin
               req_bus <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
         case (cycles % 600 < 120 ? 0 : 1)
            0: rsp_stall <= 1'b0;
            default: rsp_stall <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   // monitor: accepts, predicts and checks at the rising edge
   always @(posedge clock) begin
      upload_rsp_t exp_r;
      cycles <= cycles + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_upload(req_bus));
            accepted <= accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            received <= received + 1;
            if (rsp_bus.send_okto) acks_seen <= acks_seen + 1;
            if (rsp_bus.cancel_sent) cancels_seen <= cancels_seen + 1;
            if (expected_rsps.size() == 0) begin
               errors <= errors + 1;
               $display("%0t: unexpected response %h", $realtime, rsp_bus);
            end else begin
               exp_r = expected_rsps.pop_front();
               if (exp_r !== rsp_bus) begin
                  errors <= errors + 1;
                  $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, rsp_bus);
                  if (exp_r.resp_kind !== rsp_bus.resp_kind)
                     $display("%0t:   resp_kind expected %0d actual %0d", $realtime,
                              exp_r.resp_kind, rsp_bus.resp_kind);
                  if (exp_r.okto_position !== rsp_bus.okto_position)
                     $display("%0t:   okto_position expected %0d actual %0d", $realtime,
                              exp_r.okto_position, rsp_bus.okto_position);
                  if (exp_r.cancel_reason !== rsp_bus.cancel_reason)
                     $display("%0t:   cancel_reason expected %0d actual %0d", $realtime,
                              exp_r.cancel_reason, rsp_bus.cancel_reason);
               end
            end
         end
      end
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_FIRST_TO:   r_first_to = val;
         REG_BLOCK_TO:   r_block_to = val;
         REG_OVERALL_TO: r_overall_to = val;
         REG_RETRIES:    r_retries = val[7:0];
         REG_DEF_BLOCK:  r_def_block = val[15:0];
         REG_DEF_BATCH:  r_def_batch = val[15:0];
         REG_BATCH_MAX:  r_batch_max = val[22:0];
         default:        r_firmware = val[0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic upload_req_t mk_req(logic [2:0] c);
      upload_req_t r;
      r = '0;
      r.cmd = c;
      return r;
   endfunction

   task automatic push_start(logic [31:0] len, logic [15:0] hb, logic [15:0] ht,
                             logic [15:0] cm);
      upload_req_t r;
      r = mk_req(CMD_START);
      r.file_length = len;
      r.host_block_size = hb;
      r.host_batch_size = ht;
      r.channel_block_max = cm;
      r.block_position = $urandom();
      pending_reqs.push_back(r);
   endtask

   task automatic push_block(logic [31:0] pos, logic [15:0] blen, logic err);
      upload_req_t r;
      r = mk_req(CMD_BLOCK);
      r.block_position = pos;
      r.block_length = blen;
      r.sink_error = err;
      r.file_length = $urandom();
      pending_reqs.push_back(r);
   endtask

   // a well-formed upload with random noise, ticks and broken blocks
   task automatic push_session();
      logic [31:0] pos, len;
      logic [15:0] blen;
      int unsigned nblk;
      nblk = $urandom_range(1, 20);
      blen = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 64));
      len = ($urandom_range(0, 7) == 0) ? $urandom() : 32'(nblk) * blen;
      push_start(len, ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom()),
                 ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 8)),
                 ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom()));
      pos = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFF0 : 32'd0;
      for (int i = 0; i < nblk; i++) begin
         case ($urandom_range(0, 19))
            0: push_block($urandom(), 16'($urandom()), 1'($urandom_range(0, 1)));
            1: pending_reqs.push_back(mk_req(CMD_TICK));
            2: push_block(pos, blen, $urandom_range(0, 3) == 0);
            3: pending_reqs.push_back(mk_req(3'($urandom_range(0, 7))));
            default: begin
               push_block(pos, blen, 1'b0);
               pos = pos + blen;
            end
         endcase
      end
      if ($urandom_range(0, 3) != 0) pending_reqs.push_back(mk_req(CMD_END));
   endtask

   initial begin
      r_first_to = 32'd10000; r_block_to = 32'd2000; r_overall_to = 32'd7200000;
      r_retries = 8'd5; r_def_block = 16'd500; r_def_batch = 16'd40;
      r_batch_max = 23'd50000; r_firmware = 1'b0;
      s_uploading = 1'b0; s_exp_pos = '0; s_length = '0; s_valid_cnt = '0; s_now = '0;
      s_last_msg = '0; s_start = '0; s_batch_cnt = '0; s_blk_size = '0;
      s_batch_size = '0; s_retry_cnt = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle data, host cancel, odd commands, start clamps
      push_block(32'd0, 16'd10, 1'b0);
      pending_reqs.push_back(mk_req(CMD_CANCEL));
      for (int c = 5; c < 8; c++) pending_reqs.push_back(mk_req(3'(c)));
      pending_reqs.push_back(mk_req(CMD_TICK));
      push_start(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_start(32'd100, 16'd1, 16'd0, 16'd3);
      push_start(32'd100, 16'd0, 16'd0, 16'd0);
      push_block(32'd0, 16'd50, 1'b0);
      push_start(32'd100, 16'd0, 16'd0, 16'd0);
      push_block(32'd50, 16'hFFFF, 1'b0);
      push_block(32'd7, 16'd0, 1'b1);
      pending_reqs.push_back(mk_req(CMD_END));
      push_start(32'd0, 16'd64, 16'd2, 16'd0);
      push_block(32'd0, 16'd0, 1'b1);
      push_start(32'd1000, 16'd64, 16'd2, 16'd0);
      push_block(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      pending_reqs.push_back(mk_req(CMD_TICK));
      pending_reqs.push_back(mk_req(CMD_END));
      wait_drained();

      // tight timeouts, firmware reasons and extremes
      write_reg(REG_FIRST_TO, 32'd0);
      write_reg(REG_BLOCK_TO, 32'd1);
      write_reg(REG_OVERALL_TO, 32'hFFFF_FFFF);
      write_reg(REG_RETRIES, 32'd3);
      write_reg(REG_DEF_BLOCK, 32'h0000_FFFF);
      write_reg(REG_DEF_BATCH, 32'h0000_FFFF);
      write_reg(REG_BATCH_MAX, 32'h0040_0000);
      write_reg(REG_FIRMWARE, 32'd1);
      push_start(32'd50, 16'd0, 16'd0, 16'd0);
      repeat (4) pending_reqs.push_back(mk_req(CMD_TICK));
      push_start(32'd50, 16'd16, 16'd1, 16'd0);
      push_block(32'd0, 16'd16, 1'b1);
      push_start(32'd50, 16'd16, 16'd1, 16'd0);
      push_block(32'd0, 16'd16, 1'b0);
      push_block(32'd16, 16'd16, 1'b1);
      for (int i = 0; i < 60; i++) begin
         if ($urandom_range(0, 2) == 0) pending_reqs.push_back(mk_req(CMD_TICK));
         else push_session();
      end
      wait_drained();

      write_reg(REG_FIRST_TO, 32'hFFFF_FFFF);
      write_reg(REG_BLOCK_TO, 32'd0);
      write_reg(REG_OVERALL_TO, 32'd3);
      write_reg(REG_RETRIES, 32'd255);
      write_reg(REG_DEF_BLOCK, 32'd1);
      write_reg(REG_DEF_BATCH, 32'd1);
      write_reg(REG_BATCH_MAX, 32'd1);
      write_reg(REG_FIRMWARE, 32'd0);
      for (int i = 0; i < 15; i++) begin
         push_session();
         repeat ($urandom_range(0, 6)) pending_reqs.push_back(mk_req(CMD_TICK));
      end
      // hold the sender mid-stream until every response is back
      repeat (150) @(posedge clock);
      pause_sender = 1'b1;
      while (req_valid || expected_rsps.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      pause_sender = 1'b0;
      wait_drained();

      write_reg(REG_OVERALL_TO, 32'd0);
      write_reg(REG_RETRIES, 32'd0);
      write_reg(REG_BATCH_MAX, 32'd50000);
      write_reg(REG_BLOCK_TO, 32'd2);
      for (int i = 0; i < 12; i++) begin
         push_session();
         repeat ($urandom_range(0, 5)) pending_reqs.push_back(mk_req(CMD_TICK));
      end
      wait_drained();

      $display("covered %0d transactions, %0d responses, %0d acks, %0d cancels",
               accepted, received, acks_seen, cancels_seen);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
